>>> design/running_min_max_mean_variance_macros.svh
// Assertion macros shared by the running statistics modules.
`ifndef RUNNING_MIN_MAX_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MIN_MAX_MEAN_VARIANCE_MACROS_SVH
`ifndef SYNTHESIS
`define RMMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RMMV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RMMV_ASSERT_IMP(lbl, ante, cons, msg)
`define RMMV_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/rmmv_pkg.sv
// Types and constants of the running statistics block.
package rmmv_pkg;

  localparam int COUNT_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FRAC_EXT        = 16;  // Q16.16 sample to Q16.32 mean
  localparam int DIV_W           = 64;  // serial divider dividend width
  localparam int STEP_W          = $clog2(DIV_W + 1);
  localparam int PROD_EXT_W      = 128;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        count;
    logic signed [31:0] mean_value;
    logic [63:0]        variance;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIVM,
    ST_MUPD,
    ST_MUL,
    ST_ACC,
    ST_VSTART,
    ST_DIVV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic eval;
    logic div_mean;
    logic div_var;
    logic mean_upd;
    logic mul_step;
    logic m2_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
  } sts_t;

endpackage

>>> design/running_min_max_mean_variance.sv
// Top level of the running min, max, mean and variance block.
// Usage:
//  - in channel (in_valid/in_ready/in_data): one signed Q16.16 sample per
//    transaction; restart set clears the statistics before the sample counts.
//  - out channel (out_valid/out_ready/out_data): exactly one result per input
//    transaction: count, Q16.16 mean, Q32.32 variance, min, max, saturated.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data): max_floor_enable, always
//    ready, used at the next restart; write only while the block is idle.
// Sequence: the mean update runs a serial divider, the deviation product a
// bit-serial multiplier and the variance the same divider; a new sample is
// taken only after the result is loaded. When the count is full the sample
// is dropped and only the variance division runs.
// One transaction is worked at a time.
// The result sits in an output register, so a new sample is taken while it
// waits; a stalled receiver holds the finished next result in the controller
// until the register frees. Reset (synchronous) clears the statistics and
// sets max_floor_enable.
module running_min_max_mean_variance import rmmv_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // the cfg register is always ready for a write
  assign cfg_ready = 1'b1;

  rmmv_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmmv_dp #(.COUNT_BITS(COUNT_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

>>> design/rmmv_div.sv
// Serial radix-2 restoring divider, one quotient bit per cycle.
module rmmv_div import rmmv_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  input  logic [STEP_W-1:0]     steps,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                  busy;
  logic [STEP_W-1:0]     cnt;
  logic [DIV_W-1:0]      dreg;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign shifted  = {rem, dreg[DIV_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = !diff[COUNT_BITS];
  assign done     = busy && (cnt == STEP_W'(1));
  assign quotient = dreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) busy <= 1'b0;
    end
  end

  // divisor held for the whole run
  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dreg <= {dreg[DIV_W-2:0], ge};
      rem  <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end
  end

endmodule

>>> design/rmmv_dp.sv
// Datapath: statistics registers, serial multiplier, divider and result register.
`include "running_min_max_mean_variance_macros.svh"
module rmmv_dp import rmmv_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  localparam int MW = SAMPLE_BITS + FRAC_EXT;
  localparam int PW = 2 * MW;

  logic                          floor_en;
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          restart_q;
  logic [COUNT_BITS-1:0]         count;
  logic [MW-1:0]                 mean;
  logic [63:0]                   m2;
  logic signed [SAMPLE_BITS-1:0] min_v;
  logic signed [SAMPLE_BITS-1:0] max_v;
  logic                          neg;
  logic [MW-1:0]                 mag;
  logic [MW-1:0]                 mplr;
  logic [MW-1:0]                 mcand;
  logic [PW-1:0]                 acc;
  logic                          sat_q;

  logic [63:0]          raw;
  logic [MW-1:0]        xe;
  logic [MW:0]          d;
  logic [MW:0]          nd;
  logic [MW-1:0]        mag_c;
  logic                 full;
  logic [DIV_W-1:0]     quot;
  logic [MW-1:0]        q;
  logic                 div_done;
  logic [DIV_W-1:0]     dividend;
  logic [COUNT_BITS-1:0] divisor;
  logic [STEP_W-1:0]    steps;
  logic [PROD_EXT_W-1:0] pext;
  logic [63:0]          prod;
  logic [64:0]          sum;
  logic [SAMPLE_BITS-1:0] mean_q16;

  assign raw   = 64'($unsigned(in_data.sample));
  assign xe    = {x, {FRAC_EXT{1'b0}}};
  assign d     = {xe[MW-1], xe} - {mean[MW-1], mean};
  assign nd    = -d;
  assign mag_c = d[MW] ? nd[MW-1:0] : d[MW-1:0];
  assign full  = (count == {COUNT_BITS{1'b1}});
  assign q     = quot[MW-1:0];

  assign dividend = cmd.div_var ? m2 : (DIV_W'(mag_c) << (DIV_W - MW));
  assign divisor  = cmd.div_var ? count : count + COUNT_BITS'(1);
  assign steps    = cmd.div_var ? STEP_W'(DIV_W) : STEP_W'(MW);

  rmmv_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_mean || cmd.div_var),
    .dividend (dividend),
    .divisor  (divisor),
    .steps    (steps),
    .done     (div_done),
    .quotient (quot)
  );

  // deviation product >> 32, saturated to 64 bits
  assign pext = PROD_EXT_W'(acc);
  assign prod = (|pext[127:96]) ? {64{1'b1}} : pext[95:32];
  assign sum  = {1'b0, m2} + {1'b0, prod};

  assign mean_q16 = mean[MW-1:FRAC_EXT];

  assign sts.full     = full;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_en <= 1'b1;
    end else if (cfg_valid) begin
      floor_en <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      m2    <= '0;
      min_v <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_v <= '0;
    end else begin
      if (cmd.prep && restart_q) begin
        count <= '0;
        mean  <= '0;
        m2    <= '0;
        min_v <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        max_v <= floor_en ? '0 : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
      if (cmd.eval && !full) begin
        count <= count + COUNT_BITS'(1);
        if (x < min_v) min_v <= x;
        if (x > max_v) max_v <= x;
      end
      if (cmd.mean_upd) mean <= neg ? mean - q : mean + q;
      if (cmd.m2_upd) m2 <= sum[64] ? {64{1'b1}} : sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x         <= $signed(raw[SAMPLE_BITS-1:0]);
      restart_q <= in_data.restart;
    end
    if (cmd.eval) begin
      sat_q <= full;
      neg   <= d[MW];
      mag   <= mag_c;
    end
    if (cmd.mean_upd) begin
      mplr  <= mag;
      mcand <= mag - q;
      acc   <= '0;
    end
    if (cmd.mul_step) begin
      acc  <= {acc[PW-2:0], 1'b0} + (mplr[MW-1] ? PW'(mcand) : PW'(0));
      mplr <= {mplr[MW-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      out_data.count      <= 32'(count);
      out_data.mean_value <= 32'($signed(mean_q16));
      out_data.variance   <= quot;
      out_data.minimum    <= 32'(min_v);
      out_data.maximum    <= 32'(max_v);
      out_data.saturated  <= sat_q;
    end
  end

  `RMMV_ASSERT_NXT(a_m2_monotone, cmd.m2_upd, m2 >= $past(m2), "M2 fell on update")
  `RMMV_ASSERT_NXT(a_count_step, cmd.eval && !full, count == COUNT_BITS'($past(count) + 1), "count did not step")
  `RMMV_ASSERT_NXT(a_full_hold, cmd.eval && full, count == $past(count), "count moved while full")

endmodule

>>> design/rmmv_ctrl.sv
// Controller: sequences one transaction through the datapath.
`include "running_min_max_mean_variance_macros.svh"
module rmmv_ctrl import rmmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int MW    = SAMPLE_BITS + FRAC_EXT;
  localparam int MUL_W = $clog2(MW);

  state_t           state, state_next;
  logic [MUL_W-1:0] mul_cnt, mul_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      mul_cnt <= mul_cnt_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    mul_cnt_next = mul_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.eval = 1'b1;
        if (sts.full) begin
          cmd.div_var = 1'b1;
          state_next  = ST_DIVV;
        end else begin
          cmd.div_mean = 1'b1;
          state_next   = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (sts.div_done) state_next = ST_MUPD;
      end
      ST_MUPD: begin
        cmd.mean_upd = 1'b1;
        mul_cnt_next = MUL_W'(MW - 1);
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (mul_cnt == '0) state_next = ST_ACC;
        else mul_cnt_next = mul_cnt - MUL_W'(1);
      end
      ST_ACC: begin
        cmd.m2_upd = 1'b1;
        state_next = ST_VSTART;
      end
      ST_VSTART: begin
        cmd.div_var = 1'b1;
        state_next  = ST_DIVV;
      end
      ST_DIVV: begin
        if (sts.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RMMV_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `RMMV_ASSERT_NXT(a_mul_follows, cmd.mean_upd, cmd.mul_step, "multiply did not follow mean update")
  `RMMV_ASSERT_IMP(a_one_div, cmd.div_mean || cmd.div_var, !(cmd.div_mean && cmd.div_var), "two divider starts")

endmodule
